/* sv/bm3d_pkg.sv */
`default_nettype none
package bm3d_pkg;

	localparam int MAX_DIM_DEF = 32;
	localparam int SE_DIM_DEF  = 4;

	// register indexes of the configuration port
	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_SE_MASK  = 3'd1;
	localparam logic [2:0] REG_ORIGIN_X = 3'd2;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd3;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd4;
	localparam logic [2:0] REG_SIZE_X   = 3'd5;
	localparam logic [2:0] REG_SIZE_Y   = 3'd6;
	localparam logic [2:0] REG_SIZE_Z   = 3'd7;

	// request kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [63:0] SE_MASK_RST = 64'd1;
	localparam logic [5:0]  SIZE_RST    = 6'd32;

	typedef logic [7:0] voxel_t;

endpackage
`default_nettype wire

/* sv/bm3d_if.sv */
`default_nettype none
interface bm3d_in_if;
	import bm3d_pkg::*;
	logic   valid;
	logic   ready;
	logic   kind;
	voxel_t voxel_in;
	logic   load_last;
	modport source (output valid, kind, voxel_in, load_last, input ready);
	modport sink (input valid, kind, voxel_in, load_last, output ready);
endinterface

interface bm3d_out_if;
	import bm3d_pkg::*;
	logic   valid;
	logic   ready;
	voxel_t voxel_out;
	logic   status;
	logic   read_last;
	modport source (output valid, voxel_out, status, read_last, input ready);
	modport sink (input valid, voxel_out, status, read_last, output ready);
endinterface

interface bm3d_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/bm3d_ram.sv */
`default_nettype none
module bm3d_ram #(
	parameter int W = 8,
	parameter int D = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] addr,
	input  wire logic [W-1:0]         wdata,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

/* sv/binary_morph_3d_dilate_erode_core.sv */
`default_nettype none
// Channel | Dir | Handshake     | Payload
// din     | in  | valid / ready | kind, voxel_in, load_last
// dout    | out | valid / ready | voxel_out, status, read_last
// cfg     | in  | valid / ready | index (register 0..7), data
//
// A load is written when accepted; a read result passes rd_pend_s1, then the output register.
// A run (load with load_last) first clears the stamp memory over the last run's volume
// (the whole memory on the first run after reset), one entry a cycle, then, unless rejected,
// visits each voxel in S_VOX and S_CHK, fetches the six neighbours of a member voxel in
// S_NB and S_NBE, and for a boundary voxel steps through the 64 element points in S_SE,
// one element point a cycle through the single stamp memory port. Reset clears control only;
// din stays stalled after reset and after a register write, while the volume size settles.
module binary_morph_3d_dilate_erode_core
	import bm3d_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int SE_DIM  = SE_DIM_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bm3d_in_if.sink   din,
	bm3d_out_if.source dout,
	bm3d_cfg_if.sink  cfg
);
	localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);
	localparam int CW    = $clog2(MAX_DIM);
	localparam int SW    = $clog2(MAX_DIM + 1);
	localparam int PSW   = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int PW    = CW + 3;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_VOX  = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_NB   = 3'd4;
	localparam logic [2:0] S_NBE  = 3'd5;
	localparam logic [2:0] S_SE   = 3'd6;

	// configuration registers
	logic        mode_q;
	logic [63:0] mask_q;
	logic [1:0]  ox_q, oy_q, oz_q;
	logic [5:0]  szx_q, szy_q, szz_q;
	logic [1:0]  cfg_busy_q;

	logic [SW-1:0]  sx, sy, sz;
	logic [PSW-1:0] ps_q;
	logic [NW-1:0]  n_q;

	logic [2:0]    state_q;
	logic [AW-1:0] lp_q, rp_q, w_q;
	logic [NW-1:0] clr_cnt_q, clear_n_q;
	logic          stamp_ok_q, fill_q, rejected_q;
	logic [CW-1:0] x_q, y_q, z_q;
	logic [2:0]    nb_q;
	logic          nbv_s1, edge_q;
	logic [5:0]    pt_q;

	logic          v_s1, v_s2;
	logic [CW-1:0] px_s1, py_s1, pz_s1;
	logic [AW-1:0] pzp_s2, pyx_s2;

	logic          rd_pend_s1, rd_last_s1;
	logic          out_valid_q, out_status_q, out_last_q;
	voxel_t        out_voxel_q;

	logic          src_we, stm_we, stm_wdata, stm_rdata;
	logic [AW-1:0] src_addr, stm_addr;
	voxel_t        src_rdata;

	function automatic logic [SW-1:0] clamp_dim(input logic [5:0] v);
		if (v == 6'd0) begin
			return SW'(1);
		end else if (32'(v) > MAX_DIM) begin
			return SW'(MAX_DIM);
		end
		return SW'(v);
	endfunction

	assign sx = clamp_dim(szx_q);
	assign sy = clamp_dim(szy_q);
	assign sz = clamp_dim(szz_q);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			mask_q     <= SE_MASK_RST;
			ox_q       <= '0;
			oy_q       <= '0;
			oz_q       <= '0;
			szx_q      <= SIZE_RST;
			szy_q      <= SIZE_RST;
			szz_q      <= SIZE_RST;
			cfg_busy_q <= 2'd2;
		end else if (cfg.valid) begin
			cfg_busy_q <= 2'd2;
			unique case (cfg.index)
				REG_MODE:     mode_q <= cfg.data[0];
				REG_SE_MASK:  mask_q <= cfg.data;
				REG_ORIGIN_X: ox_q   <= cfg.data[1:0];
				REG_ORIGIN_Y: oy_q   <= cfg.data[1:0];
				REG_ORIGIN_Z: oz_q   <= cfg.data[1:0];
				REG_SIZE_X:   szx_q  <= cfg.data[5:0];
				REG_SIZE_Y:   szy_q  <= cfg.data[5:0];
				REG_SIZE_Z:   szz_q  <= cfg.data[5:0];
				default:      ;
			endcase
		end else if (cfg_busy_q != 2'd0) begin
			cfg_busy_q <= cfg_busy_q - 2'd1;
		end
	end

	// volume size settles through ps_q, then n_q, after a size write
	always_ff @(posedge clk) begin
		ps_q <= PSW'(sx) * PSW'(sy);
		n_q  <= NW'(ps_q) * NW'(sz);
	end

	// request side
	logic          in_acc, ld_acc, rd_acc;
	logic [AW-1:0] lp_sel, rp_sel, lp_nxt, rp_nxt;

	assign din.ready = (state_q == S_IDLE) && !rd_pend_s1 && !v_s1 && !v_s2 &&
		(cfg_busy_q == 2'd0) && (!out_valid_q || dout.ready);
	assign in_acc = din.valid && din.ready;
	assign ld_acc = in_acc && (din.kind == KIND_LOAD);
	assign rd_acc = in_acc && (din.kind == KIND_READ);

	assign lp_sel = (NW'(lp_q) >= n_q) ? '0 : lp_q;
	assign rp_sel = (NW'(rp_q) >= n_q) ? '0 : rp_q;
	assign lp_nxt = (NW'(lp_sel) + NW'(1) >= n_q) ? '0 : lp_sel + AW'(1);
	assign rp_nxt = (NW'(rp_sel) + NW'(1) >= n_q) ? '0 : rp_sel + AW'(1);

	// membership test follows the mode: object voxels dilate, background voxels erode
	logic src_member;
	assign src_member = mode_q ? (src_rdata == '0) : (src_rdata != '0);

	// neighbour address and in-volume test
	logic [AW-1:0] nb_addr;
	logic          nb_in;
	always_comb begin
		nb_addr = w_q;
		nb_in   = 1'b0;
		case (nb_q)
			3'd0: begin
				nb_addr = w_q - AW'(1);
				nb_in   = x_q != '0;
			end
			3'd1: begin
				nb_addr = w_q + AW'(1);
				nb_in   = (32'(x_q) + 1) < 32'(sx);
			end
			3'd2: begin
				nb_addr = w_q - AW'(sx);
				nb_in   = y_q != '0;
			end
			3'd3: begin
				nb_addr = w_q + AW'(sx);
				nb_in   = (32'(y_q) + 1) < 32'(sy);
			end
			3'd4: begin
				nb_addr = w_q - AW'(ps_q);
				nb_in   = z_q != '0;
			end
			3'd5: begin
				nb_addr = w_q + AW'(ps_q);
				nb_in   = (32'(z_q) + 1) < 32'(sz);
			end
			default: ;
		endcase
	end

	logic edge_now;
	assign edge_now = edge_q || (nbv_s1 && !src_member);

	// element point of the current step, shifted by the origin
	logic signed [PW-1:0] px_c, py_c, pz_c;
	logic                 pt_ok;
	assign px_c = $signed(PW'(x_q) + PW'(pt_q[1:0]) - PW'(ox_q));
	assign py_c = $signed(PW'(y_q) + PW'(pt_q[3:2]) - PW'(oy_q));
	assign pz_c = $signed(PW'(z_q) + PW'(pt_q[5:4]) - PW'(oz_q));
	assign pt_ok = mask_q[pt_q] &&
		(32'(pt_q[1:0]) < SE_DIM) && (32'(pt_q[3:2]) < SE_DIM) && (32'(pt_q[5:4]) < SE_DIM) &&
		!px_c[PW-1] && (px_c < $signed(PW'(sx))) &&
		!py_c[PW-1] && (py_c < $signed(PW'(sy))) &&
		!pz_c[PW-1] && (pz_c < $signed(PW'(sz)));

	logic rejecting, last_vox;
	assign rejecting = (32'(ox_q) >= SE_DIM) || (32'(oy_q) >= SE_DIM) ||
		(32'(oz_q) >= SE_DIM) || !mask_q[{oz_q, oy_q, ox_q}];
	assign last_vox = (32'(x_q) + 1 == 32'(sx)) && (32'(y_q) + 1 == 32'(sy)) &&
		(32'(z_q) + 1 == 32'(sz));

	logic advance, inject_ctr;
	assign inject_ctr = (state_q == S_NBE) && !edge_now;
	assign advance = ((state_q == S_CHK) && !src_member) || inject_ctr ||
		((state_q == S_SE) && (pt_q == 6'd63));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lp_q       <= '0;
			rp_q       <= '0;
			w_q        <= '0;
			clr_cnt_q  <= '0;
			clear_n_q  <= NW'(DEPTH);
			stamp_ok_q <= 1'b0;
			fill_q     <= 1'b1;
			rejected_q <= 1'b0;
			x_q        <= '0;
			y_q        <= '0;
			z_q        <= '0;
			nb_q       <= '0;
			nbv_s1     <= 1'b0;
			edge_q     <= 1'b0;
			pt_q       <= '0;
		end else begin
			nbv_s1 <= (state_q == S_NB) && nb_in;
			// the final load of a volume returns the load pointer to the start
			if (ld_acc) begin
				lp_q <= din.load_last ? '0 : lp_nxt;
			end
			if (rd_acc) begin
				rp_q <= rp_nxt;
			end
			unique case (state_q)
				S_IDLE: begin
					if (ld_acc && din.load_last) begin
						rp_q      <= '0;
						fill_q    <= !mode_q;
						clr_cnt_q <= '0;
						state_q   <= S_CLR;
					end
				end
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + NW'(1);
					if (clr_cnt_q + NW'(1) >= clear_n_q) begin
						clear_n_q  <= n_q;
						stamp_ok_q <= 1'b1;
						rejected_q <= rejecting;
						x_q        <= '0;
						y_q        <= '0;
						z_q        <= '0;
						w_q        <= '0;
						state_q    <= rejecting ? S_IDLE : S_VOX;
					end
				end
				S_VOX: state_q <= S_CHK;
				S_CHK: begin
					nb_q   <= '0;
					edge_q <= 1'b0;
					if (src_member) begin
						state_q <= S_NB;
					end
				end
				S_NB: begin
					// evaluate the neighbour fetched last cycle, fetch the next
					edge_q <= edge_now;
					nb_q   <= nb_q + 3'd1;
					if (nb_q == 3'd5) begin
						state_q <= S_NBE;
					end
				end
				S_NBE: begin
					pt_q <= '0;
					if (edge_now) begin
						state_q <= S_SE;
					end
				end
				S_SE: pt_q <= pt_q + 6'd1;
				default: state_q <= S_IDLE;
			endcase
			if (advance) begin
				if (last_vox) begin
					state_q <= S_IDLE;
				end else begin
					state_q <= S_VOX;
					w_q     <= w_q + AW'(1);
					if (32'(x_q) + 1 == 32'(sx)) begin
						x_q <= '0;
						if (32'(y_q) + 1 == 32'(sy)) begin
							y_q <= '0;
							z_q <= z_q + CW'(1);
						end else begin
							y_q <= y_q + CW'(1);
						end
					end else begin
						x_q <= x_q + CW'(1);
					end
				end
			end
		end
	end

	// stamp address pipeline: clip, then z product and y product, then add at the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ((state_q == S_SE) && pt_ok) || inject_ctr;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (inject_ctr) begin
			px_s1 <= x_q;
			py_s1 <= y_q;
			pz_s1 <= z_q;
		end else begin
			px_s1 <= px_c[CW-1:0];
			py_s1 <= py_c[CW-1:0];
			pz_s1 <= pz_c[CW-1:0];
		end
		pzp_s2 <= AW'(pz_s1) * AW'(ps_q);
		pyx_s2 <= AW'(py_s1) * AW'(sx) + AW'(px_s1);
	end

	// memory ports
	always_comb begin
		src_we   = ld_acc;
		src_addr = rp_sel;
		if (ld_acc) begin
			src_addr = lp_sel;
		end else if (state_q == S_VOX) begin
			src_addr = w_q;
		end else if (state_q == S_NB) begin
			src_addr = nb_addr;
		end
		stm_we    = (state_q == S_CLR) || v_s2;
		stm_wdata = (state_q != S_CLR);
		stm_addr  = rp_sel;
		if (state_q == S_CLR) begin
			stm_addr = AW'(clr_cnt_q);
		end else if (v_s2) begin
			stm_addr = pzp_s2 + pyx_s2;
		end
	end

	bm3d_ram #(.W(8), .D(DEPTH)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.addr  (src_addr),
		.wdata (din.voxel_in),
		.rdata (src_rdata)
	);

	bm3d_ram #(.W(1), .D(DEPTH)) u_stamp_ram (
		.clk   (clk),
		.we    (stm_we),
		.addr  (stm_addr),
		.wdata (stm_wdata),
		.rdata (stm_rdata)
	);

	// read results: hold in the output register until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_acc;
			if (rd_pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_acc) begin
			rd_last_s1 <= (NW'(rp_sel) + NW'(1) == n_q);
		end
		if (rd_pend_s1) begin
			out_voxel_q  <= (stamp_ok_q && stm_rdata) ? {8{fill_q}} : src_rdata;
			out_status_q <= rejected_q;
			out_last_q   <= rd_last_s1;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.voxel_out = out_voxel_q;
	assign dout.status    = out_status_q;
	assign dout.read_last = out_last_q;

`ifndef ASSERT_OFF
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(rd_pend_s1))
		else $error("result shown without a read");
	a_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == S_IDLE) && !v_s2)
		else $error("read overlaps a run");
	a_clr_no_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !v_s1 && !v_s2)
		else $error("stamp write during clear");
	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !$past(out_valid_q) || $past(dout.ready) || !out_valid_q)
		else $error("result overwritten");
`endif
endmodule
`default_nettype wire

/* bench/morph_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module morph_checker
	import bm3d_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	bm3d_in_if        din,
	bm3d_out_if       dout,
	bm3d_cfg_if       cfg,
	output int        fail_count,
	output int        pending_count,
	output int        results_seen
);

	localparam int VOL_WORDS = MAX_DIM_DEF * MAX_DIM_DEF * MAX_DIM_DEF;

	typedef struct packed {
		voxel_t voxel;
		logic   status;
		logic   last;
	} voxel_result_t;

	logic        erode_mode;
	logic [63:0] element_mask;
	logic [1:0]  org_x, org_y, org_z;
	logic [5:0]  dim_x, dim_y, dim_z;

	voxel_t      src_volume [VOL_WORDS];
	bit          stamped    [VOL_WORDS];
	int unsigned load_ptr, read_ptr;
	logic        run_rejected;
	voxel_t      stamp_fill;

	voxel_result_t expected_voxels [$];

	function automatic int unsigned clamp_dim(logic [5:0] v);
		if (v == 6'd0) return 1;
		if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
		return v;
	endfunction

	function automatic bit is_member(voxel_t v, bit erode);
		return erode ? (v == 8'd0) : (v != 8'd0);
	endfunction

	// Work out the stamp map of one run over the loaded volume.
	function automatic void stamp_volume();
		int sx, sy, sz, ps, w, x, y, z, i, j, k, px, py, pz;
		bit on_boundary;
		sx = clamp_dim(dim_x);
		sy = clamp_dim(dim_y);
		sz = clamp_dim(dim_z);
		ps = sx * sy;
		foreach (stamped[n]) stamped[n] = 1'b0;
		stamp_fill = erode_mode ? 8'd0 : 8'd255;
		if (!element_mask[org_z * 16 + org_y * 4 + org_x]) begin
			run_rejected = 1'b1;
			return;
		end
		run_rejected = 1'b0;
		for (z = 0; z < sz; z++)
		for (y = 0; y < sy; y++)
		for (x = 0; x < sx; x++) begin
			w = z * ps + y * sx + x;
			if (!is_member(src_volume[w], erode_mode)) continue;
			on_boundary = 1'b0;
			if (x > 0 && !is_member(src_volume[w - 1], erode_mode)) on_boundary = 1'b1;
			if (x + 1 < sx && !is_member(src_volume[w + 1], erode_mode)) on_boundary = 1'b1;
			if (y > 0 && !is_member(src_volume[w - sx], erode_mode)) on_boundary = 1'b1;
			if (y + 1 < sy && !is_member(src_volume[w + sx], erode_mode)) on_boundary = 1'b1;
			if (z > 0 && !is_member(src_volume[w - ps], erode_mode)) on_boundary = 1'b1;
			if (z + 1 < sz && !is_member(src_volume[w + ps], erode_mode)) on_boundary = 1'b1;
			if (!on_boundary) begin
				stamped[w] = 1'b1;
				continue;
			end
			for (k = 0; k < SE_DIM_DEF; k++)
			for (j = 0; j < SE_DIM_DEF; j++)
			for (i = 0; i < SE_DIM_DEF; i++) begin
				if (!element_mask[k * 16 + j * 4 + i]) continue;
				px = x + i - org_x;
				py = y + j - org_y;
				pz = z + k - org_z;
				if (px < 0 || px >= sx || py < 0 || py >= sy || pz < 0 || pz >= sz) continue;
				stamped[pz * ps + py * sx + px] = 1'b1;
			end
		end
	endfunction

	initial begin
		foreach (src_volume[n]) src_volume[n] = 8'd0;
		foreach (stamped[n]) stamped[n] = 1'b0;
		fail_count    = 0;
		results_seen  = 0;
		pending_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		int unsigned   nvox;
		voxel_result_t want;
		if (!arst_n) begin
			erode_mode   = 1'b0;
			element_mask = SE_MASK_RST;
			org_x        = 2'd0;
			org_y        = 2'd0;
			org_z        = 2'd0;
			dim_x        = SIZE_RST;
			dim_y        = SIZE_RST;
			dim_z        = SIZE_RST;
			load_ptr     = 0;
			read_ptr     = 0;
			run_rejected = 1'b0;
			stamp_fill   = 8'd255;
			expected_voxels.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MODE:     erode_mode   = cfg.data[0];
					REG_SE_MASK:  element_mask = cfg.data;
					REG_ORIGIN_X: org_x        = cfg.data[1:0];
					REG_ORIGIN_Y: org_y        = cfg.data[1:0];
					REG_ORIGIN_Z: org_z        = cfg.data[1:0];
					REG_SIZE_X:   dim_x        = cfg.data[5:0];
					REG_SIZE_Y:   dim_y        = cfg.data[5:0];
					REG_SIZE_Z:   dim_z        = cfg.data[5:0];
					default: ;
				endcase
			end
			nvox = clamp_dim(dim_x) * clamp_dim(dim_y) * clamp_dim(dim_z);
			if (din.valid && din.ready) begin
				if (din.kind == KIND_LOAD) begin
					if (load_ptr >= nvox) load_ptr = 0;
					src_volume[load_ptr] = din.voxel_in;
					load_ptr++;
					if (load_ptr >= nvox) load_ptr = 0;
					if (din.load_last) begin
						stamp_volume();
						load_ptr = 0;
						read_ptr = 0;
					end
				end else begin
					if (read_ptr >= nvox) read_ptr = 0;
					want.voxel  = stamped[read_ptr] ? stamp_fill : src_volume[read_ptr];
					want.status = run_rejected;
					want.last   = (read_ptr + 1 == nvox);
					expected_voxels.push_back(want);
					read_ptr++;
					if (read_ptr >= nvox) read_ptr = 0;
				end
			end
			if (dout.valid && dout.ready) begin
				results_seen++;
				if (expected_voxels.size() == 0) begin
					$display("%0t: unexpected result voxel=%0d status=%0d last=%0d", $time,
						dout.voxel_out, dout.status, dout.read_last);
					fail_count++;
				end else begin
					want = expected_voxels.pop_front();
					if (dout.voxel_out !== want.voxel) begin
						$display("%0t: voxel_out expected %0d actual %0d", $time,
							want.voxel, dout.voxel_out);
						fail_count++;
					end
					if (dout.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, dout.status);
						fail_count++;
					end
					if (dout.read_last !== want.last) begin
						$display("%0t: read_last expected %0d actual %0d", $time,
							want.last, dout.read_last);
						fail_count++;
					end
				end
			end
		end
		pending_count = expected_voxels.size();
	end

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import bm3d_pkg::*;

	// Longest stretch with no accepted request: the first run clears the
	// whole stamp memory, then visits a volume of up to 64 voxels.
	localparam int IDLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 1100;

	logic clk;
	logic arst_n;

	bm3d_in_if  din_bus ();
	bm3d_out_if dout_bus ();
	bm3d_cfg_if cfg_bus ();

	int fail_count, pending_count, results_seen;

	// stimulus-side copies of the volume size, needed to size each load/read pass
	logic [5:0] size_x_w, size_y_w, size_z_w;
	int   items_sent;
	int   volumes_run;
	bit   no_gaps;      // sender offers back to back
	bit   no_stalls;    // receiver always ready
	bit   hold_req;     // ask the receiver for one long hold-off
	int   idle_cycles;

	binary_morph_3d_dilate_erode_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_bus),
		.dout   (dout_bus),
		.cfg    (cfg_bus)
	);

	morph_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.din           (din_bus),
		.dout          (dout_bus),
		.cfg           (cfg_bus),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.results_seen  (results_seen)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Watchdog: end the run if nothing is accepted for too long.
	always @(posedge clk) begin
		if ((din_bus.valid && din_bus.ready) || (dout_bus.valid && dout_bus.ready) ||
			(cfg_bus.valid && cfg_bus.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Pick a random gap length: mostly none or short, now and then long.
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Receiver: stall at random, or hold off for a long stretch on request.
	initial begin
		int stall;
		dout_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				dout_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				dout_bus.ready <= 1'b1;
			end else if (no_stalls) begin
				dout_bus.ready <= 1'b1;
			end else begin
				stall = random_gap();
				if (stall == 0) begin
					dout_bus.ready <= 1'b1;
				end else begin
					dout_bus.ready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	// Offer one request; called just after a falling edge, returns likewise
	// with valid still high so that back-to-back requests need no toggle.
	task automatic send_request(input logic kind, input voxel_t value, input logic last);
		int gap;
		gap = no_gaps ? 0 : random_gap();
		if (gap > 0) begin
			din_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_bus.valid     <= 1'b1;
		din_bus.kind      <= kind;
		din_bus.voxel_in  <= value;
		din_bus.load_last <= last;
		do @(posedge clk); while (!din_bus.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Drop valid and wait until every result is back and the block is quiet.
	task automatic drain();
		din_bus.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		case (idx)
			REG_SIZE_X: size_x_w = value[5:0];
			REG_SIZE_Y: size_y_w = value[5:0];
			REG_SIZE_Z: size_z_w = value[5:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [5:0] sx, input logic [5:0] sy, input logic [5:0] sz);
		write_reg(REG_SIZE_X, {58'd0, sx});
		write_reg(REG_SIZE_Y, {58'd0, sy});
		write_reg(REG_SIZE_Z, {58'd0, sz});
	endtask

	function automatic voxel_t random_voxel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 8'd0;
		if (r < 65) return 8'd255;
		return 8'($urandom_range(1, 255));
	endfunction

	// Load a whole volume, then read it back plus a few wrapped reads.
	// Read requests carry random voxel_in and load_last, which the block ignores.
	task automatic process_volume(input int extra_reads, input bit squeeze);
		int nvox, v, sx, sy, sz;
		cfg_bus.valid <= 1'b0;
		sx = (size_x_w == 0) ? 1 : (size_x_w > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(size_x_w);
		sy = (size_y_w == 0) ? 1 : (size_y_w > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(size_y_w);
		sz = (size_z_w == 0) ? 1 : (size_z_w > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(size_z_w);
		nvox = sx * sy * sz;
		for (v = 0; v < nvox; v++)
			send_request(KIND_LOAD, random_voxel(), v == nvox - 1);
		if (squeeze) hold_req = 1'b1;
		for (v = 0; v < nvox + extra_reads; v++)
			send_request(KIND_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		volumes_run++;
		drain();
	endtask

	function automatic logic [63:0] random_mask(input int ox, input int oy, input int oz);
		logic [63:0] m;
		int bitpos, r;
		bitpos = oz * 16 + oy * 4 + ox;
		r = $urandom_range(0, 99);
		m = {$urandom(), $urandom()};
		if (r < 15) m = '1;
		else if (r < 25) m = 64'd0;
		else if (r < 35) m = 64'd0 | ({63'd0, 1'b1} << bitpos);
		// about one run in eight is rejected: clear the origin bit
		if ($urandom_range(0, 7) == 0) m[bitpos] = 1'b0;
		else m[bitpos] = 1'b1;
		return m;
	endfunction

	initial begin
		int ox, oy, oz, r;
		logic [5:0] sx, sy, sz;
		arst_n            = 1'b0;
		din_bus.valid     = 1'b0;
		din_bus.kind      = KIND_LOAD;
		din_bus.voxel_in  = 8'd0;
		din_bus.load_last = 1'b0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.index     = REG_MODE;
		cfg_bus.data      = 64'd0;
		size_x_w = SIZE_RST;
		size_y_w = SIZE_RST;
		size_z_w = SIZE_RST;
		items_sent  = 0;
		volumes_run = 0;
		no_gaps     = 1'b0;
		no_stalls   = 1'b0;
		hold_req    = 1'b0;
		idle_cycles = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: dilation with the reset element, a tiny 2x2x1 volume.
		set_geometry(6'd2, 6'd2, 6'd1);
		process_volume(0, 1'b0);

		// Directed: erosion with a full element and the origin at the far corner.
		write_reg(REG_MODE, 64'd1);
		write_reg(REG_SE_MASK, '1);
		write_reg(REG_ORIGIN_X, 64'd3);
		write_reg(REG_ORIGIN_Y, 64'd3);
		write_reg(REG_ORIGIN_Z, 64'd3);
		set_geometry(6'd2, 6'd1, 6'd2);
		process_volume(0, 1'b0);

		// Directed: origin bit clear, so the run is rejected; zero size counts as one.
		write_reg(REG_MODE, 64'd0);
		write_reg(REG_SE_MASK, ~(64'd1 << 63));
		set_geometry(6'd0, 6'd1, 6'd1);
		process_volume(2, 1'b0);

		// Directed: oversized x counts as 32, with a long receiver hold-off.
		write_reg(REG_SE_MASK, 64'h8000_0000_0000_0000);
		set_geometry(6'd63, 6'd1, 6'd1);
		process_volume(0, 1'b1);

		// Random phases: fresh settings, random contents.
		while (items_sent < ITEM_TARGET) begin
			no_gaps   = ($urandom_range(0, 5) == 0);
			no_stalls = ($urandom_range(0, 5) == 0);
			ox = $urandom_range(0, 3);
			oy = $urandom_range(0, 3);
			oz = $urandom_range(0, 3);
			write_reg(REG_MODE, {63'd0, 1'($urandom_range(0, 1))});
			write_reg(REG_ORIGIN_X, 64'(ox));
			write_reg(REG_ORIGIN_Y, 64'(oy));
			write_reg(REG_ORIGIN_Z, 64'(oz));
			write_reg(REG_SE_MASK, random_mask(ox, oy, oz));
			// mostly small volumes; now and then one full-length axis
			r = $urandom_range(0, 99);
			sx = 6'($urandom_range(1, 4));
			sy = 6'($urandom_range(1, 4));
			sz = 6'($urandom_range(1, 4));
			if (r < 6) begin
				sx = 6'd32; sy = 6'($urandom_range(1, 2)); sz = 6'd1;
			end else if (r < 12) begin
				sx = 6'd1; sy = 6'd32; sz = 6'($urandom_range(1, 2));
			end else if (r < 18) begin
				sx = 6'($urandom_range(1, 2)); sy = 6'd1; sz = 6'd32;
			end else if (r < 22) begin
				sx = 6'd0;
			end
			set_geometry(sx, sy, sz);
			process_volume(($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 5)) : 0,
				($urandom_range(0, 15) == 0));
		end

		no_gaps   = 1'b0;
		no_stalls = 1'b0;
		drain();
		repeat (20) @(negedge clk);
		$display("Ran %0d volumes: %0d requests, %0d result voxels checked,", volumes_run,
			items_sent, results_seen);
		$display("both modes, rejected runs, clipped elements and wrapped reads included.");
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
